// File: hdl/blkmm_pkg.sv
`timescale 1ns / 1ps

package blkmm_pkg;

  localparam int MAX_DIM_DEFAULT = 32;

  localparam int DATA_W       = 32;
  localparam int ROW_W        = 5;
  localparam int COL_W        = 5;
  localparam int CMD_W        = 3;
  localparam int CFG_W        = 6;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [CFG_W-1:0] MATRIX_SIZE_RST = 6'd32;
  localparam logic [CFG_W-1:0] TILE_SIZE_RST   = 6'd8;

  // Register index, taken from paddr[2]
  localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;
  localparam logic [0:0] REG_TILE_SIZE   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A = 3'd0,
    CMD_WR_B = 3'd1,
    CMD_WR_C = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_RD_C = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_MUL_DRAIN,
    ST_MUL_STORE,
    ST_MUL_DONE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     status;
  } out_item_t;

endpackage

// File: hdl/blocked_matrix_multiply_accumulate_top.sv
`timescale 1ns / 1ps

// Integer matrix multiply-accumulate engine, C += A * B, on square matrices of
// up to MAX_DIM x MAX_DIM 32-bit elements held in three on-chip memories. Each
// input transfer carries one command (write A, write B, write C, multiply,
// read C) and yields exactly one output transfer with read data and a status
// bit that flags a row or column outside the matrix size in use. The block
// works on one command at a time: element writes and out-of-range commands
// answer in the next cycle after acceptance, while a C read passes through
// the C memory read register and then the output register. A multiply runs
// through one shared multiplier and adder: for every (i, j) it loads C[i][j],
// streams n products A[i][k] * B[k][j] through a read/multiply/add pipeline
// and writes the sum back. Products and sums wrap modulo 2^32. After reset
// the block zeroes the accumulator memory one word per cycle and holds
// in_stall_o high meanwhile; the APB port is open at all times. tile_size is
// stored and readable but does not change results. Registers: matrix_size at
// byte 0x0 (0 acts as 1, values above MAX_DIM act as MAX_DIM), tile_size at
// 0x4. Change them only while no command is in flight.
module blocked_matrix_multiply_accumulate_top
  import blkmm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,

  // Command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,

  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int N_W    = $clog2(MAX_DIM + 1);
  localparam int ADDR_W = 2 * DIM_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CMP_W  = (N_W > ROW_W) ? N_W : ROW_W;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
    return {r, c};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] matrix_size_q;
  logic [CFG_W-1:0] tile_size_q;
  logic             cfg_we;
  logic [0:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= MATRIX_SIZE_RST;
      tile_size_q   <= TILE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MATRIX_SIZE: matrix_size_q <= pwdata[CFG_W-1:0];
        REG_TILE_SIZE:   tile_size_q   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MATRIX_SIZE: prdata = PDATA_W'(matrix_size_q);
      REG_TILE_SIZE:   prdata = PDATA_W'(tile_size_q);
      default:         prdata = '0;
    endcase
  end

  // Clamp the programmed size into 1..MAX_DIM
  logic [N_W-1:0] n_use;
  logic [N_W-1:0] n_last;

  always_comb begin
    if (matrix_size_q == '0) begin
      n_use = N_W'(1);
    end else if (32'(matrix_size_q) > 32'(MAX_DIM)) begin
      n_use = N_W'(MAX_DIM);
    end else begin
      n_use = N_W'(matrix_size_q);
    end
  end

  assign n_last = n_use - N_W'(1);

  // ---------------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------------
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;

  assign in_range = (CMP_W'(in_item_i.row) < CMP_W'(n_use)) &&
                    (CMP_W'(in_item_i.col) < CMP_W'(n_use));
  assign in_addr  = cell_addr(DIM_W'(in_item_i.row), DIM_W'(in_item_i.col));

  // ---------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [DIM_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  // MAC pipeline: issue -> operand regs (s1) -> product reg (s2) -> accumulate
  logic              issue;
  logic              s1_q, s2_q, c_pend_q;
  logic [DATA_W-1:0] a_rd_q, b_rd_q, c_rd_q, prod_q, acc_q;

  // Output register
  logic              out_valid_q;
  out_item_t         out_q, out_d;
  logic              out_load;
  logic              out_free;
  logic              accept;

  // Memory port controls
  logic              a_we, b_we, c_we, a_re, b_re, c_re;
  logic [ADDR_W-1:0] a_waddr, b_waddr, c_waddr, a_raddr, b_raddr, c_raddr;
  logic [DATA_W-1:0] ab_wdata, c_wdata;

  logic i_end, j_end, k_end, clr_end;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && (state_q == ST_IDLE) && out_free;
  assign i_end    = (N_W'(i_q) == n_last);
  assign j_end    = (N_W'(j_q) == n_last);
  assign k_end    = (N_W'(k_q) == n_last);
  assign clr_end  = (clr_q == ADDR_W'(DEPTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.cmd == CMD_MUL) begin
            state_d = ST_MUL_LOAD;
          end else if (in_item_i.cmd == CMD_RD_C && in_range) begin
            state_d = ST_RD_WAIT;
          end
        end
      end
      ST_RD_WAIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_MUL_LOAD:  state_d = ST_MUL_RUN;
      ST_MUL_RUN: begin
        if (k_end) state_d = ST_MUL_DRAIN;
      end
      ST_MUL_DRAIN: begin
        if (!s1_q && !s2_q) state_d = ST_MUL_STORE;
      end
      ST_MUL_STORE: begin
        state_d = (i_end && j_end) ? ST_MUL_DONE : ST_MUL_LOAD;
      end
      ST_MUL_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o = !((state_q == ST_IDLE) && out_free);
    issue      = 1'b0;
    out_load   = 1'b0;
    out_d      = '0;
    a_we       = 1'b0;
    b_we       = 1'b0;
    c_we       = 1'b0;
    a_re       = 1'b0;
    b_re       = 1'b0;
    c_re       = 1'b0;
    a_waddr    = in_addr;
    b_waddr    = in_addr;
    c_waddr    = in_addr;
    ab_wdata   = in_item_i.value;
    c_wdata    = in_item_i.value;
    a_raddr    = cell_addr(i_q, k_q);
    b_raddr    = cell_addr(k_q, j_q);
    c_raddr    = in_addr;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    clr_d      = clr_q;

    unique case (state_q)
      ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_q;
        c_wdata = '0;
        clr_d   = clr_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          out_d.status = 1'b0;
          unique case (in_item_i.cmd)
            CMD_WR_A: begin
              a_we         = in_range;
              out_load     = 1'b1;
              out_d.status = !in_range;
            end
            CMD_WR_B: begin
              b_we         = in_range;
              out_load     = 1'b1;
              out_d.status = !in_range;
            end
            CMD_WR_C: begin
              c_we         = in_range;
              out_load     = 1'b1;
              out_d.status = !in_range;
            end
            CMD_RD_C: begin
              // Inside reads answer from RD_WAIT once the word is out
              c_re         = in_range;
              out_load     = !in_range;
              out_d.status = !in_range;
            end
            CMD_MUL: begin
              i_d = '0;
              j_d = '0;
              k_d = '0;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_RD_WAIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_d.read_data = c_rd_q;
        end
      end
      ST_MUL_LOAD: begin
        c_re    = 1'b1;
        c_raddr = cell_addr(i_q, j_q);
      end
      ST_MUL_RUN: begin
        issue = 1'b1;
        a_re  = 1'b1;
        b_re  = 1'b1;
        k_d   = k_end ? '0 : k_q + DIM_W'(1);
      end
      ST_MUL_DRAIN: ;
      ST_MUL_STORE: begin
        c_we    = 1'b1;
        c_waddr = cell_addr(i_q, j_q);
        c_wdata = acc_q;
        if (j_end) begin
          j_d = '0;
          i_d = i_end ? '0 : i_q + DIM_W'(1);
        end else begin
          j_d = j_q + DIM_W'(1);
        end
      end
      ST_MUL_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      clr_q    <= '0;
      s1_q     <= 1'b0;
      s2_q     <= 1'b0;
      c_pend_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      clr_q    <= clr_d;
      s1_q     <= issue;
      s2_q     <= s1_q;
      c_pend_q <= (state_q == ST_MUL_LOAD);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiply-accumulate unit
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      prod_q <= DATA_W'(a_rd_q * b_rd_q);
    end
    // Seed with the old C word, then add one product per cycle
    if (c_pend_q) begin
      acc_q <= c_rd_q;
    end else if (s2_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Matrix memories
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] a_mem [DEPTH];
  logic [DATA_W-1:0] b_mem [DEPTH];
  logic [DATA_W-1:0] c_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem[a_waddr] <= ab_wdata;
    if (a_re) a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) b_mem[b_waddr] <= ab_wdata;
    if (b_re) b_rd_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) c_mem[c_waddr] <= c_wdata;
    if (c_re) c_rd_q <= c_mem[c_raddr];
  end

  // ---------------------------------------------------------------------------
  // Output register: load when empty or draining, else hold
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: test/blocked_matrix_multiply_accumulate_top_test.sv
`timescale 1ns / 1ps

// Checks the matrix multiply-accumulate block through its command and result
// channels and its APB register port.
module blocked_matrix_multiply_accumulate_top_test;
  import blkmm_pkg::*;

  localparam int DIM            = MAX_DIM_DEFAULT;
  localparam int CELLS          = DIM * DIM;
  localparam int ITEM_BUDGET    = 1450;
  localparam int MAX_IDLE       = 12;
  // Above this size a random phase runs no multiply: loading its operands
  // would outweigh the rest of the run.
  localparam int BIG_SIZE       = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_WAIT_LIMIT = 50000;
  localparam int N_DIRECTED     = 25;

  // Command codes the block has no operation for.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam logic [PADDR_W-1:0] ADDR_MATRIX_SIZE = {REG_MATRIX_SIZE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_TILE_SIZE   = {REG_TILE_SIZE, 2'b00};

  localparam logic [DATA_W-1:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MAX_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ALL_ONE = 32'hffff_ffff;

  // One row of the directed table. Where known is set the result is typed in
  // here; otherwise it comes from the predictor.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              known;
    logic [DATA_W-1:0] want_data;
    logic              want_status;
  } directed_step_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_item_o;

  blocked_matrix_multiply_accumulate_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Shadow copy of the three matrices and the two registers.
  logic [DATA_W-1:0] left_m  [CELLS];
  logic [DATA_W-1:0] right_m [CELLS];
  logic [DATA_W-1:0] acc_m   [CELLS];
  bit                left_set  [CELLS];
  bit                right_set [CELLS];
  logic [CFG_W-1:0]  size_reg;
  logic [CFG_W-1:0]  tile_reg;

  out_item_t pending_responses[$];

  int unsigned mismatch_count  = 0;
  int unsigned commands_sent   = 0;
  int unsigned multiplies      = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 0;
  // When set, that side runs back to back without idling.
  bit          tx_steady       = 1'b0;
  bit          rx_steady       = 1'b0;

  // Directed table, walked at matrix size 2: reset contents, indexes at and
  // beyond the edge, unused command codes, extreme operands, two multiplies.
  directed_step_t directed_steps [N_DIRECTED] = '{
    '{CMD_RD_C,      5'd0,  5'd0,  32'h0,   1'b1, 32'h0,   1'b0},
    '{CMD_RD_C,      5'd1,  5'd1,  32'h0,   1'b1, 32'h0,   1'b0},
    '{CMD_RD_C,      5'd31, 5'd31, 32'h0,   1'b1, 32'h0,   1'b1},
    '{CMD_WR_A,      5'd2,  5'd0,  MAX_POS, 1'b1, 32'h0,   1'b1},
    '{CMD_WR_B,      5'd0,  5'd2,  MAX_NEG, 1'b1, 32'h0,   1'b1},
    '{CMD_WR_C,      5'd31, 5'd31, ALL_ONE, 1'b1, 32'h0,   1'b1},
    '{CMD_UNUSED_LO, 5'd31, 5'd31, ALL_ONE, 1'b1, 32'h0,   1'b0},
    '{CMD_UNUSED_HI, 5'd0,  5'd0,  32'h0,   1'b1, 32'h0,   1'b0},
    '{CMD_WR_A,      5'd0,  5'd0,  MAX_POS, 1'b1, 32'h0,   1'b0},
    '{CMD_WR_A,      5'd0,  5'd1,  MAX_NEG, 1'b1, 32'h0,   1'b0},
    '{CMD_WR_A,      5'd1,  5'd0,  ALL_ONE, 1'b1, 32'h0,   1'b0},
    '{CMD_WR_A,      5'd1,  5'd1,  32'h1,   1'b1, 32'h0,   1'b0},
    '{CMD_WR_B,      5'd0,  5'd0,  MAX_POS, 1'b1, 32'h0,   1'b0},
    '{CMD_WR_B,      5'd0,  5'd1,  ALL_ONE, 1'b1, 32'h0,   1'b0},
    '{CMD_WR_B,      5'd1,  5'd0,  MAX_NEG, 1'b1, 32'h0,   1'b0},
    '{CMD_WR_B,      5'd1,  5'd1,  MAX_POS, 1'b1, 32'h0,   1'b0},
    '{CMD_WR_C,      5'd0,  5'd0,  MAX_NEG, 1'b1, 32'h0,   1'b0},
    '{CMD_WR_C,      5'd1,  5'd1,  MAX_POS, 1'b1, 32'h0,   1'b0},
    '{CMD_RD_C,      5'd0,  5'd0,  32'h0,   1'b1, MAX_NEG, 1'b0},
    '{CMD_MUL,       5'd31, 5'd31, ALL_ONE, 1'b1, 32'h0,   1'b0},
    '{CMD_RD_C,      5'd0,  5'd0,  32'h0,   1'b0, 32'h0,   1'b0},
    '{CMD_RD_C,      5'd0,  5'd1,  32'h0,   1'b0, 32'h0,   1'b0},
    '{CMD_RD_C,      5'd1,  5'd0,  32'h0,   1'b0, 32'h0,   1'b0},
    '{CMD_RD_C,      5'd1,  5'd1,  32'h0,   1'b0, 32'h0,   1'b0},
    '{CMD_MUL,       5'd0,  5'd0,  32'h0,   1'b1, 32'h0,   1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop; the slowest legal run stays well below this.
  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("[%0t] mismatch in %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Matrix size actually in use: 0 acts as 1, anything above DIM as DIM.
  function automatic int unsigned active_size();
    int unsigned s;
    s = size_reg;
    if (s < 1) s = 1;
    if (s > DIM) s = DIM;
    return s;
  endfunction

  // Work out the response to one accepted command and apply its effect on
  // the shadow matrices.
  task automatic compute_response(input in_item_t it, output out_item_t res);
    int unsigned       n;
    int unsigned       idx;
    logic              in_range;
    logic [DATA_W-1:0] sum;
    n        = active_size();
    idx      = it.row * DIM + it.col;
    in_range = (it.row < n) && (it.col < n);
    res      = '0;
    case (it.cmd)
      CMD_WR_A, CMD_WR_B, CMD_WR_C, CMD_RD_C: begin
        if (!in_range) begin
          res.status = 1'b1;
        end else if (it.cmd == CMD_WR_A) begin
          left_m[idx]   = it.value;
          left_set[idx] = 1'b1;
        end else if (it.cmd == CMD_WR_B) begin
          right_m[idx]   = it.value;
          right_set[idx] = 1'b1;
        end else if (it.cmd == CMD_WR_C) begin
          acc_m[idx] = it.value;
        end else begin
          res.read_data = acc_m[idx];
        end
      end
      CMD_MUL: begin
        // Summation order is free: the sums wrap, so tiling cannot matter.
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            sum = acc_m[i * DIM + j];
            for (int k = 0; k < n; k++)
              sum = sum + left_m[i * DIM + k] * right_m[k * DIM + j];
            acc_m[i * DIM + j] = sum;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one command; on its transfer, queue the response it must cause.
  task automatic send_command(input in_item_t it, input logic known,
                              input out_item_t typed_res);
    int unsigned gap;
    out_item_t   res;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    // Drop valid only across a real gap, so back to back items keep it high.
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    compute_response(it, res);
    pending_responses.push_back(known ? typed_res : res);
    commands_sent++;
    if (it.cmd == CMD_MUL) multiplies++;
  endtask

  // Hold valid low until every queued response has arrived, then let the
  // block settle.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer: setup phase, access phase until pready, then an idle
  // phase so that the next transfer starts on a fresh edge.
  task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_registers();
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, ADDR_MATRIX_SIZE, '0, rd);
    if (rd !== PDATA_W'(size_reg))
      report_mismatch("matrix_size readback", rd, DATA_W'(size_reg));
    apb_access(1'b0, ADDR_TILE_SIZE, '0, rd);
    if (rd !== PDATA_W'(tile_reg))
      report_mismatch("tile_size readback", rd, DATA_W'(tile_reg));
  endtask

  // Write both registers with junk in the upper bits, which must be dropped.
  task automatic configure(input logic [CFG_W-1:0] sz, input logic [CFG_W-1:0] tl);
    logic [PDATA_W-1:0] wd;
    logic [PDATA_W-1:0] rd;
    wd            = $urandom;
    wd[CFG_W-1:0] = sz;
    apb_access(1'b1, ADDR_MATRIX_SIZE, wd, rd);
    size_reg      = sz;
    wd            = $urandom;
    wd[CFG_W-1:0] = tl;
    apb_access(1'b1, ADDR_TILE_SIZE, wd, rd);
    tile_reg      = tl;
    check_registers();
    settings_used++;
  endtask

  // Indexes favor the edge of the size in use and the cell just past it.
  function automatic logic [ROW_W-1:0] pick_index(input int unsigned n);
    case ($urandom_range(0, 9))
      0:       return ROW_W'(n - 1);
      1:       return (n < DIM) ? ROW_W'(n) : ROW_W'(0);
      2:       return ROW_W'($urandom_range(0, DIM - 1));
      default: return ROW_W'($urandom_range(0, n - 1));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return MAX_POS;
      1:       return MAX_NEG;
      2:       return ALL_ONE;
      3:       return '0;
      4:       return DATA_W'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // A multiply may only read operands written since reset: load any missing
  // cell of A and B inside the size in use first.
  task automatic fill_operands(input int unsigned n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < n; k++) begin
        it.row   = ROW_W'(i);
        it.col   = COL_W'(k);
        it.value = $urandom;
        if (!left_set[i * DIM + k]) begin
          it.cmd = CMD_WR_A;
          send_command(it, 1'b0, '0);
        end
        if (!right_set[i * DIM + k]) begin
          it.cmd = CMD_WR_B;
          send_command(it, 1'b0, '0);
        end
      end
    end
  endtask

  // Mostly loads, multiplies and read-backs inside the size in use, mixed
  // with out-of-range indexes and unused command codes.
  task automatic run_random_phase(input int unsigned count);
    int unsigned n;
    int unsigned pick;
    in_item_t    it;
    n = active_size();
    repeat (count) begin
      pick     = $urandom_range(0, 99);
      it.row   = pick_index(n);
      it.col   = pick_index(n);
      it.value = pick_value();
      if (pick < 25)      it.cmd = CMD_WR_A;
      else if (pick < 50) it.cmd = CMD_WR_B;
      else if (pick < 60) it.cmd = CMD_WR_C;
      else if (pick < 88) it.cmd = CMD_RD_C;
      else if (pick < 95) it.cmd = CMD_MUL;
      else                it.cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      if (it.cmd == CMD_MUL) begin
        // Large multiplies turn into reads; small ones get their operands.
        if (n > BIG_SIZE) begin
          it.cmd = CMD_RD_C;
        end else begin
          fill_operands(n);
        end
      end
      send_command(it, 1'b0, '0);
    end
  endtask

  // Result side: per result, stall for a drawn number of cycles, then take
  // the next transfer.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Compare every result transfer against the oldest queued response.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_checked++;
      if (pending_responses.size() == 0) begin
        report_mismatch("result with nothing pending", out_item_o.read_data, '0);
      end else begin
        want = pending_responses.pop_front();
        if (out_item_o.read_data !== want.read_data)
          report_mismatch("read_data", out_item_o.read_data, want.read_data);
        if (out_item_o.status !== want.status)
          report_mismatch("status", DATA_W'(out_item_o.status), DATA_W'(want.status));
      end
    end
  end

  initial begin
    in_item_t         it;
    out_item_t        typed_res;
    int unsigned      phase_no;
    int unsigned      end_wait;
    logic [CFG_W-1:0] sz;
    logic [CFG_W-1:0] tl;

    for (int c = 0; c < CELLS; c++) begin
      left_m[c]    = '0;
      right_m[c]   = '0;
      acc_m[c]     = '0;
      left_set[c]  = 1'b0;
      right_set[c] = 1'b0;
    end
    size_reg = MATRIX_SIZE_RST;
    tile_reg = TILE_SIZE_RST;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values first, then a 2x2 setting with a zero tile for the table.
    // The port refuses commands during the clearing pass; the handshake
    // takes care of that.
    check_registers();
    configure(6'd2, 6'd0);
    for (int r = 0; r < N_DIRECTED; r++) begin
      it.cmd              = directed_steps[r].cmd;
      it.row              = directed_steps[r].row;
      it.col              = directed_steps[r].col;
      it.value            = directed_steps[r].value;
      typed_res.read_data = directed_steps[r].want_data;
      typed_res.status    = directed_steps[r].want_status;
      send_command(it, directed_steps[r].known, typed_res);
    end

    // Random phases. The first few pin the size extremes: above the maximum,
    // zero, one past the maximum, one, the maximum itself.
    phase_no = 0;
    while (commands_sent < ITEM_BUDGET) begin
      case (phase_no)
        0:       sz = 6'd63;
        1:       sz = 6'd0;
        2:       sz = 6'd33;
        3:       sz = 6'd1;
        4:       sz = 6'd32;
        default: sz = ($urandom_range(0, 9) < 7) ? CFG_W'($urandom_range(1, 8))
                                                 : CFG_W'($urandom_range(0, 63));
      endcase
      case (phase_no)
        0:       tl = 6'd63;
        1:       tl = 6'd0;
        default: tl = CFG_W'($urandom_range(0, 63));
      endcase
      wait_until_idle();
      configure(sz, tl);
      run_random_phase($urandom_range(40, 100));
      phase_no++;
    end

    // Drain, with a bound, and give stray results a chance to show up.
    in_valid_i <= 1'b0;
    end_wait = 0;
    while (pending_responses.size() != 0 && end_wait < END_WAIT_LIMIT) begin
      @(posedge clk_i);
      end_wait++;
    end
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (pending_responses.size() != 0)
      report_mismatch("results never delivered", DATA_W'(pending_responses.size()), '0);

    $display("covered %0d commands, %0d of them multiplies, over %0d register settings",
             commands_sent, multiplies, settings_used);
    $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/blkmm_pkg.sv
hdl/blocked_matrix_multiply_accumulate_top.sv
test/blocked_matrix_multiply_accumulate_top_test.sv
